@@ src/sha_pkg.sv @@
// Shared types, codes and constants of the SHA-256 stream hasher.
// No dependencies; every other file uses this package.
`default_nettype none
package sha_pkg;

  // One input transaction: an optional message byte and an end mark.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_item_t;

  // One result transaction: a single digest word.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } core_state_t;

  localparam int unsigned QueueDepth = 4;
  localparam logic [7:0]  PadByte    = 8'h80;
  localparam logic [5:0]  LenStart   = 6'd56;
  localparam logic [63:0] BlockBits  = 64'd512;

  localparam logic [31:0] InitWords [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

endpackage
`default_nettype wire

@@ src/sha256_stream_hasher_unit.sv @@
// Top level of the SHA-256 stream hasher: front queue feeding the hashing core.
// Depends on sha_pkg, sha_front and sha_core.
//
//   channel | direction | payload             | handshake
//   in_     | input     | sha_pkg::in_item_t  | in_valid / in_stall
//   out_    | output    | sha_pkg::out_item_t | out_valid / out_stall
//
// The core takes one queued byte per cycle while idle and none while it compresses;
// a full block then runs through the rounds and then the chaining add.
// An end mark writes padding bytes from the fill point to the block end and runs
// the rounds, plus a whole padding block and another run of rounds when 56 or
// more bytes are held, then eight digest words at one per cycle unless stalled.
// A four-entry queue lets the sender keep going while the core compresses.
// Reset is synchronous and active low; no item is taken during reset.
// A stalled result holds its word; the core waits for the output register.
`default_nettype none
module sha256_stream_hasher_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire sha_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sha_pkg::out_item_t      out_data
);
  import sha_pkg::*;

  logic     q_valid;
  logic     q_pop;
  in_item_t q_item;

  sha_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  sha_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

@@ src/sha_front.sv @@
// Front end: accepts input transactions, drops empty ones, and queues the rest.
// Depends on sha_pkg.
`default_nettype none
module sha_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire sha_pkg::in_item_t in_data,
  output logic                   q_valid,
  output sha_pkg::in_item_t      q_item,
  input  wire logic              q_pop
);
  import sha_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  in_item_t          q_r [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PtrW:0]     cnt_r, cnt_nxt;
  logic              push;

  // Full queue holds off the sender; the flag is decoded from the count register alone.
  assign in_stall = (cnt_r == QueueDepth[PtrW:0]);
  assign q_valid  = (cnt_r != '0);
  assign q_item   = q_r[rd_ptr_r];

  // Items with neither a byte nor an end mark change nothing and are dropped.
  assign push = in_valid && !in_stall && (in_data.has_byte || in_data.end_of_message);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + {{PtrW{1'b0}}, push} - {{PtrW{1'b0}}, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage carries payload only.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_data;
    end
  end

endmodule
`default_nettype wire

@@ src/sha_core.sv @@
// Back end: block buffer, padding sequencer, round engine and digest output.
// Depends on sha_pkg.
`default_nettype none
module sha_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire sha_pkg::in_item_t q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output sha_pkg::out_item_t     out_data
);
  import sha_pkg::*;

  core_state_t state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [63:0] len_r, len_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        two_r, two_nxt;
  logic        first_r, first_nxt;
  logic        padding_r, padding_nxt;
  logic        pend_r, pend_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;
  logic [31:0] chain_r [8];
  logic [31:0] chain_nxt [8];
  logic [31:0] r_r [8];
  logic [31:0] r_nxt [8];
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];

  logic        wr_en;
  logic [5:0]  wr_pos;
  logic [7:0]  wr_byte;
  logic [6:0]  new_fill;
  logic [31:0] t1, t2, s0w, s1w, w_new;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign new_fill  = {1'b0, fill_r} + {6'd0, q_item.has_byte};

  // Round datapath and message schedule for the current round.
  always_comb begin
    s0w   = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1w   = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = w_r[0] + s0w + w_r[9] + s1w;
    t1 = r_r[7] + (rotr(r_r[4], 6) ^ rotr(r_r[4], 11) ^ rotr(r_r[4], 25))
       + ((r_r[4] & r_r[5]) ^ (~r_r[4] & r_r[6])) + RoundK[rnd_r] + w_r[0];
    t2 = (rotr(r_r[0], 2) ^ rotr(r_r[0], 13) ^ rotr(r_r[0], 22))
       + ((r_r[0] & r_r[1]) ^ (r_r[0] & r_r[2]) ^ (r_r[1] & r_r[2]));
  end

  // Sequencer: next state and every next register value.
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    bits_nxt      = bits_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    rnd_nxt       = rnd_r;
    cnt_nxt       = cnt_r;
    two_nxt       = two_r;
    first_nxt     = first_r;
    padding_nxt   = padding_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    chain_nxt     = chain_r;
    r_nxt         = r_r;
    w_nxt         = w_r;
    wr_en         = 1'b0;
    wr_pos        = fill_r;
    wr_byte       = q_item.data_byte;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          wr_en = q_item.has_byte;
          if (new_fill[6]) begin
            // The block is full: compress it before any end handling.
            fill_nxt    = '0;
            pend_nxt    = q_item.end_of_message;
            padding_nxt = 1'b0;
            rnd_nxt     = '0;
            r_nxt       = chain_r;
            state_nxt   = ST_ROUND;
          end else begin
            fill_nxt = new_fill[5:0];
            if (q_item.end_of_message) begin
              pos_nxt     = new_fill[5:0];
              first_nxt   = 1'b1;
              len_nxt     = bits_r + {55'd0, new_fill[5:0], 3'd0};
              two_nxt     = (new_fill[5:0] >= LenStart);
              padding_nxt = 1'b1;
              state_nxt   = ST_PAD;
            end
          end
        end
      end
      ST_ROUND: begin
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[15] = w_new;
        for (int i = 1; i < 8; i++) begin
          r_nxt[i] = r_r[i-1];
        end
        r_nxt[4] = r_r[3] + t1;
        r_nxt[0] = t1 + t2;
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        for (int i = 0; i < 8; i++) begin
          chain_nxt[i] = chain_r[i] + r_r[i];
        end
        if (!padding_r) begin
          bits_nxt = bits_r + BlockBits;
          if (pend_r) begin
            // End mark arrived with the block's last byte: pad an empty tail.
            pend_nxt    = 1'b0;
            pos_nxt     = '0;
            first_nxt   = 1'b1;
            len_nxt     = bits_r + BlockBits;
            two_nxt     = 1'b0;
            padding_nxt = 1'b1;
            state_nxt   = ST_PAD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else if (two_r) begin
          // The length did not fit; build a second block of zeros and length.
          two_nxt   = 1'b0;
          pos_nxt   = '0;
          state_nxt = ST_PAD;
        end else begin
          cnt_nxt   = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_PAD: begin
        wr_en     = 1'b1;
        wr_pos    = pos_r;
        first_nxt = 1'b0;
        if (first_r) begin
          wr_byte = PadByte;
        end else if (!two_r && pos_r >= LenStart) begin
          wr_byte = 8'(len_r >> {~pos_r[2:0], 3'd0});
        end else begin
          wr_byte = 8'd0;
        end
        if (pos_r == 6'd63) begin
          rnd_nxt   = '0;
          r_nxt     = chain_r;
          state_nxt = ST_ROUND;
        end else begin
          pos_nxt = pos_r + 6'd1;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt       = 1'b1;
          out_nxt.digest_word = chain_r[cnt_r];
          out_nxt.word_index  = cnt_r;
          out_nxt.last_word   = (cnt_r == 3'd7);
          cnt_nxt             = cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            // Digest handed off: return to the initial chaining state.
            chain_nxt   = InitWords;
            fill_nxt    = '0;
            bits_nxt    = '0;
            padding_nxt = 1'b0;
            state_nxt   = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Byte write into the big-endian word window.
    if (wr_en) begin
      w_nxt[wr_pos[5:2]][{~wr_pos[1:0], 3'd0} +: 8] = wr_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      bits_r      <= '0;
      cnt_r       <= '0;
      two_r       <= 1'b0;
      first_r     <= 1'b0;
      padding_r   <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      chain_r     <= InitWords;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      bits_r      <= bits_nxt;
      cnt_r       <= cnt_nxt;
      two_r       <= two_nxt;
      first_r     <= first_nxt;
      padding_r   <= padding_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      chain_r     <= chain_nxt;
    end
  end

  // Datapath registers carry payload only.
  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    pos_r <= pos_nxt;
    rnd_r <= rnd_nxt;
    out_r <= out_nxt;
    r_r   <= r_nxt;
    w_r   <= w_nxt;
  end

endmodule
`default_nettype wire

@@ src/sha_checker.sv @@
// Port-level checks of the SHA-256 stream hasher, bound to the top level.
// Depends on sha_pkg and sha256_stream_hasher_unit.
`default_nettype none
module sha_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire sha_pkg::out_item_t out_data
);

  // A stalled result transaction keeps its word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // The last-word flag marks exactly the eighth digest word.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
    else $error("last_word disagrees with word_index");

  // Reset leaves no result pending.
  a_reset_out: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

  // Reset empties the queue so the sender is not held off.
  a_reset_in: assert property (@(posedge clk)
    $past(!rst_n) |-> !in_stall)
    else $error("input stalled after reset");

endmodule

bind sha256_stream_hasher_unit sha_checker u_sha_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

@@ tb/sv/sha256_stream_hasher_unit_test.sv @@
// Self-checking testbench of the SHA-256 stream hasher unit.
// Depends on sha_pkg and sha256_stream_hasher_unit; predicts each digest in software.
`timescale 1ns / 1ps
`default_nettype none

// Holds the expected digest words and a software copy of the hashing state.
class digest_scoreboard;
  logic [31:0] chain [8];
  logic [7:0]  block_bytes [64];
  int unsigned fill;
  logic [63:0] done_bits;
  sha_pkg::out_item_t pending_words [$];
  int unsigned error_count;
  int unsigned digest_count;

  function new();
    restart();
    error_count = 0;
    digest_count = 0;
  endfunction

  // Return the hashing state to its start values.
  function void restart();
    for (int i = 0; i < 8; i++) chain[i] = sha_pkg::InitWords[i];
    for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    fill = 0;
    done_bits = 64'd0;
  endfunction

  function logic [31:0] rot_right(logic [31:0] v, int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // Fold the buffered block into the chaining words.
  function void fold_block();
    logic [31:0] sched [64];
    logic [31:0] r [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      sched[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    for (int i = 16; i < 64; i++)
      sched[i] = sched[i-16] + sched[i-7]
               + (rot_right(sched[i-15], 7) ^ rot_right(sched[i-15], 18) ^ (sched[i-15] >> 3))
               + (rot_right(sched[i-2], 17) ^ rot_right(sched[i-2], 19) ^ (sched[i-2] >> 10));
    for (int i = 0; i < 8; i++) r[i] = chain[i];
    for (int i = 0; i < 64; i++) begin
      t1 = r[7] + (rot_right(r[4], 6) ^ rot_right(r[4], 11) ^ rot_right(r[4], 25))
         + ((r[4] & r[5]) ^ (~r[4] & r[6])) + sha_pkg::RoundK[i] + sched[i];
      t2 = (rot_right(r[0], 2) ^ rot_right(r[0], 13) ^ rot_right(r[0], 22))
         + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
      r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
      r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + r[i];
  endfunction

  // Note an accepted input transaction and queue any digest it finishes.
  function void note_input(sha_pkg::in_item_t item);
    logic [63:0] total;
    int unsigned pos;
    sha_pkg::out_item_t word;
    if (item.has_byte) begin
      block_bytes[fill] = item.data_byte;
      fill++;
      if (fill == 64) begin
        fold_block();
        done_bits += 64'd512;
        fill = 0;
      end
    end
    if (!item.end_of_message) return;
    total = done_bits + 64'(fill) * 8;
    pos = fill;
    block_bytes[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin block_bytes[pos] = 8'h00; pos++; end
      fold_block();
      pos = 0;
    end
    while (pos < 56) begin block_bytes[pos] = 8'h00; pos++; end
    for (int i = 0; i < 8; i++) block_bytes[63-i] = total[8*i +: 8];
    fold_block();
    for (int i = 0; i < 8; i++) begin
      word.digest_word = chain[i];
      word.word_index = 3'(i);
      word.last_word = (i == 7);
      pending_words.push_back(word);
    end
    digest_count++;
    restart();
  endfunction

  // Compare an accepted result transaction with the oldest expected word.
  function void check_result(sha_pkg::out_item_t got);
    sha_pkg::out_item_t want;
    if (pending_words.size() == 0) begin
      $error("unexpected digest word %h with no expectation", got.digest_word);
      error_count++;
      return;
    end
    want = pending_words.pop_front();
    if (got.digest_word !== want.digest_word) begin
      $error("digest_word: expected %h, actual %h", want.digest_word, got.digest_word);
      error_count++;
    end
    if (got.word_index !== want.word_index) begin
      $error("word_index: expected %0d, actual %0d", want.word_index, got.word_index);
      error_count++;
    end
    if (got.last_word !== want.last_word) begin
      $error("last_word: expected %0b, actual %0b", want.last_word, got.last_word);
      error_count++;
    end
  endfunction
endclass

module sha256_stream_hasher_unit_test;
  import sha_pkg::*;

  localparam int unsigned IdleLimit = 20000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  digest_scoreboard board;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_off_req;
  int unsigned quiet_cycles;
  int unsigned bytes_sent;

  sha256_stream_hasher_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Send one transaction, with random idle cycles before it.
  task automatic send_item(input logic [7:0] b, input logic has, input logic fin);
    in_item_t item;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    item.data_byte = b;
    item.has_byte = has;
    item.end_of_message = fin;
    in_data <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    board.note_input(item);
    if (has) bytes_sent++;
    @(negedge clk);
  endtask

  // Send a message of the given length with random bytes.
  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_item(8'($urandom), 1'b1, (i == len - 1));
    if (len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Stop offering transactions and wait for every expected word.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (board.pending_words.size() != 0) @(negedge clk);
  endtask

  // Receiver stall generation, including a long hold-off on request.
  initial begin
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        for (int i = 0; i < 400; i++) @(negedge clk);
        hold_off_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Result monitor and watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) board.check_result(out_data);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    board = new();
    in_valid = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_req = 1'b0;
    quiet_cycles = 0;
    bytes_sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty message, idle items, extreme bytes, byte with end mark.
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'haa, 1'b0, 1'b0);
    send_item(8'h55, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    // Sender pauses until every digest word has come back.
    wait_drained();
    send_item(8'h00, 1'b1, 1'b1);
    wait_drained();

    // Long receiver hold-off while the sender keeps going: the queue fills.
    hold_off_req = 1'b1;
    send_message(8);
    send_message(6);
    wait_drained();

    // Random phases of short messages; one longer message reaches the
    // padding and block boundaries.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      for (int m = 0; m < 2; m++) begin
        case ($urandom_range(3))
          0: send_message(0);
          1: begin
            send_item(8'($urandom), 1'b0, 1'b0);
            send_message($urandom_range(1, 4));
          end
          default: send_message($urandom_range(1, 8));
        endcase
      end
      if (phase == 0) send_message($urandom_range(56, 64));
    end

    wait_drained();
    repeat (300) @(negedge clk);
    $display("Run covered %0d digests over %0d message bytes,", board.digest_count, bytes_sent);
    $display("including empty, boundary-length and multi-block messages under stalls.");
    if (board.error_count == 0 && board.pending_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

`default_nettype wire
